// ===== rtl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and codes of the quoted string unescaper: result kinds,
// error codes, character constants and the command word that travels
// from the classifier to the result stage.
// ----------------------------------------------------------------------------
package qsu_pkg;

    localparam int CP_W      = 21;
    localparam int KIND_W    = 2;
    localparam int ERR_W     = 3;
    localparam int MODE_W    = 2;
    localparam int HEX_W     = 32;
    localparam int HEX_CNT_W = 4;

    localparam int DEF_MAX_BRACED_DIGITS = 8;
    localparam int DEF_FIXED_HEX_DIGITS  = 4;
    localparam int DEF_QUEUE_DEPTH       = 2;

    localparam logic [KIND_W-1:0] K_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] K_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] K_ERROR = 2'd2;

    localparam logic [ERR_W-1:0] E_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] E_LINE   = 3'd1;
    localparam logic [ERR_W-1:0] E_EOD    = 3'd2;
    localparam logic [ERR_W-1:0] E_ESCAPE = 3'd3;
    localparam logic [ERR_W-1:0] E_HEX    = 3'd4;
    localparam logic [ERR_W-1:0] E_LONG   = 3'd5;
    localparam logic [ERR_W-1:0] E_SCALAR = 3'd6;
    localparam logic [ERR_W-1:0] E_FAULT  = 3'd7;

    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REGEX = 2'd1;

    localparam logic [CP_W-1:0] CP_TAB       = 21'h09;
    localparam logic [CP_W-1:0] CP_LF        = 21'h0A;
    localparam logic [CP_W-1:0] CP_CR        = 21'h0D;
    localparam logic [CP_W-1:0] CP_QUOTE     = 21'h22;
    localparam logic [CP_W-1:0] CP_DOLLAR    = 21'h24;
    localparam logic [CP_W-1:0] CP_SLASH     = 21'h2F;
    localparam logic [CP_W-1:0] CP_BACKSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CP_BACKTICK  = 21'h60;
    localparam logic [CP_W-1:0] CP_LBRACE    = 21'h7B;
    localparam logic [CP_W-1:0] CP_RBRACE    = 21'h7D;

    // One classified item: a single result, or a backslash beat followed
    // by the character when dbl is set.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CP_W-1:0]   cp;
        logic [ERR_W-1:0]  err;
        logic              dbl;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

// ===== rtl/qsu_front.sv =====
// ----------------------------------------------------------------------------
// qsu_front
// Classifier: holds the mode register and the escape state, turns each
// accepted character into at most one command for the result stage.
// ----------------------------------------------------------------------------
module qsu_front
    import qsu_pkg::*;
#(
    parameter int MAX_BRACED_DIGITS = DEF_MAX_BRACED_DIGITS,
    parameter int FIXED_HEX_DIGITS  = DEF_FIXED_HEX_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic [CP_W-1:0]   i_code_point,
    input  logic              i_end_of_data,
    input  logic              i_decode_fault,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESCAPE,
        PH_AFTER_U,
        PH_FIXED,
        PH_BRACED,
        PH_FINISHED
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [MODE_W-1:0]     r_mode;
    logic [HEX_W-1:0]      r_hex, n_hex;
    logic [HEX_CNT_W-1:0]  r_cnt, n_cnt;

    logic                  hex_ok;
    logic [3:0]            hex_val;
    logic [HEX_W-1:0]      hex_shift;
    logic [HEX_CNT_W-1:0]  cnt_inc;
    logic [CP_W-1:0]       term;
    logic                  do_fail;
    logic [ERR_W-1:0]      fail_err;
    logic                  do_hex;
    logic [HEX_W-1:0]      hex_out;

    function automatic logic [4:0] hex_of(input logic [CP_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, 4'(c - 21'h30)};
        end else if (c >= 21'h41 && c <= 21'h46) begin
            r = {1'b1, 4'(c - 21'h37)};
        end else if (c >= 21'h61 && c <= 21'h66) begin
            r = {1'b1, 4'(c - 21'h57)};
        end
        return r;
    endfunction

    function automatic logic scalar_ok(input logic [HEX_W-1:0] v);
        return !(v == '0 || v > 32'h0010_FFFF || (v >= 32'hD800 && v <= 32'hDFFF));
    endfunction

    assign {hex_ok, hex_val} = hex_of(i_code_point);
    assign hex_shift = {r_hex[HEX_W-5:0], hex_val};
    assign cnt_inc   = HEX_CNT_W'(r_cnt + 1'b1);

    always_comb begin
        case (r_mode)
            MODE_TEXT:  term = CP_QUOTE;
            MODE_REGEX: term = CP_SLASH;
            default:    term = CP_BACKTICK;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_hex       = r_hex;
        n_cnt       = r_cnt;
        o_cmd_valid = 1'b0;
        o_cmd.kind  = K_CHAR;
        o_cmd.cp    = i_code_point;
        o_cmd.err   = E_NONE;
        o_cmd.dbl   = 1'b0;
        do_fail     = 1'b0;
        fail_err    = E_NONE;
        do_hex      = 1'b0;
        hex_out     = hex_shift;

        if (i_accept && r_phase != PH_FINISHED) begin
            if (i_end_of_data) begin
                do_fail  = 1'b1;
                fail_err = E_EOD;
            end else if (i_decode_fault) begin
                do_fail  = 1'b1;
                fail_err = E_FAULT;
            end else if (i_code_point == CP_LF || i_code_point == CP_CR) begin
                do_fail  = 1'b1;
                fail_err = E_LINE;
            end else begin
                case (r_phase)
                    PH_NORMAL: begin
                        if (i_code_point == term) begin
                            n_phase     = PH_FINISHED;
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = K_DONE;
                            o_cmd.cp    = '0;
                        end else if (i_code_point == CP_BACKSLASH &&
                                     (r_mode == MODE_TEXT || r_mode == MODE_REGEX)) begin
                            n_phase = PH_ESCAPE;
                        end else begin
                            o_cmd_valid = 1'b1;
                        end
                    end
                    PH_ESCAPE: begin
                        n_phase = PH_NORMAL;
                        if (r_mode == MODE_REGEX) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.dbl   = (i_code_point != CP_SLASH);
                        end else begin
                            case (i_code_point)
                                CP_BACKSLASH, CP_QUOTE, CP_DOLLAR: o_cmd_valid = 1'b1;
                                21'h74, 21'h54: begin
                                    o_cmd_valid = 1'b1;
                                    o_cmd.cp    = CP_TAB;
                                end
                                21'h6E, 21'h4E: begin
                                    o_cmd_valid = 1'b1;
                                    o_cmd.cp    = CP_LF;
                                end
                                21'h72, 21'h52: begin
                                    o_cmd_valid = 1'b1;
                                    o_cmd.cp    = CP_CR;
                                end
                                21'h75, 21'h55: begin
                                    n_phase = PH_AFTER_U;
                                    n_hex   = '0;
                                    n_cnt   = '0;
                                end
                                default: begin
                                    do_fail  = 1'b1;
                                    fail_err = E_ESCAPE;
                                end
                            endcase
                        end
                    end
                    PH_AFTER_U: begin
                        if (i_code_point == CP_LBRACE) begin
                            n_phase = PH_BRACED;
                            n_hex   = '0;
                            n_cnt   = '0;
                        end else if (!hex_ok) begin
                            do_fail  = 1'b1;
                            fail_err = E_HEX;
                        end else begin
                            n_hex   = HEX_W'(hex_val);
                            hex_out = HEX_W'(hex_val);
                            n_cnt   = HEX_CNT_W'(1);
                            if (HEX_CNT_W'(1) >= HEX_CNT_W'(FIXED_HEX_DIGITS)) begin
                                do_hex = 1'b1;
                            end else begin
                                n_phase = PH_FIXED;
                            end
                        end
                    end
                    PH_FIXED: begin
                        if (!hex_ok) begin
                            do_fail  = 1'b1;
                            fail_err = E_HEX;
                        end else begin
                            n_hex = hex_shift;
                            n_cnt = cnt_inc;
                            if (cnt_inc >= HEX_CNT_W'(FIXED_HEX_DIGITS)) begin
                                do_hex = 1'b1;
                            end
                        end
                    end
                    PH_BRACED: begin
                        if (hex_ok) begin
                            if (r_cnt >= HEX_CNT_W'(MAX_BRACED_DIGITS)) begin
                                do_fail  = 1'b1;
                                fail_err = E_LONG;
                            end else begin
                                n_hex = hex_shift;
                                n_cnt = cnt_inc;
                            end
                        end else if (i_code_point == CP_RBRACE && r_cnt != '0) begin
                            do_hex  = 1'b1;
                            hex_out = r_hex;
                        end else begin
                            do_fail  = 1'b1;
                            fail_err = E_HEX;
                        end
                    end
                    default: n_phase = PH_FINISHED;
                endcase
            end

            if (do_hex) begin
                n_phase = PH_NORMAL;
                if (scalar_ok(hex_out)) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.cp    = hex_out[CP_W-1:0];
                end else begin
                    do_fail  = 1'b1;
                    fail_err = E_SCALAR;
                end
            end

            if (do_fail) begin
                n_phase     = PH_FINISHED;
                o_cmd_valid = 1'b1;
                o_cmd.kind  = K_ERROR;
                o_cmd.cp    = '0;
                o_cmd.err   = fail_err;
                o_cmd.dbl   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_mode  <= MODE_TEXT;
            r_hex   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FINISHED |-> !o_cmd_valid)
        else $error("command issued after the string ended");

    a_end_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && o_cmd.kind != K_CHAR |=> r_phase == PH_FINISHED)
        else $error("done or error beat did not close the string");

endmodule

// ===== rtl/qsu_queue.sv =====
// ----------------------------------------------------------------------------
// qsu_queue
// Short command queue between classifier and result stage.
// ----------------------------------------------------------------------------
module qsu_queue
    import qsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_cmd  i_cmd,
    input  logic  i_rd,
    output logic  o_full,
    output t_head o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.cmd    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_rd) begin
                r_rd <= ptr_next(r_rd);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= CNT_W'(r_count + 1'b1);
                2'b01:   r_count <= CNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("command written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_head.valid)
        else $error("command read from an empty queue");

endmodule

// ===== rtl/qsu_back.sv =====
// ----------------------------------------------------------------------------
// qsu_back
// Result stage: expands each command into one or two result beats and
// holds the oldest beat in the output register until it is popped.
// ----------------------------------------------------------------------------
module qsu_back
    import qsu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_head             i_head,
    output logic              o_deq,
    input  logic              pop,
    output logic              empty,
    output logic [KIND_W-1:0] o_result_kind,
    output logic [CP_W-1:0]   o_out_code_point,
    output logic [ERR_W-1:0]  o_error_code,
    output logic              o_last_of_run
);

    logic r_valid;
    logic r_half;
    logic load;
    logic first_of_two;

    assign empty        = !r_valid;
    assign load         = (!r_valid || pop) && i_head.valid;
    assign first_of_two = i_head.cmd.dbl && !r_half;
    assign o_deq        = load && !first_of_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_half  <= first_of_two;
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    // payload: backslash beat first for a two-beat command
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_of_two) begin
                o_result_kind    <= K_CHAR;
                o_out_code_point <= CP_BACKSLASH;
                o_error_code     <= E_NONE;
                o_last_of_run    <= 1'b0;
            end else begin
                o_result_kind    <= i_head.cmd.kind;
                o_out_code_point <= i_head.cmd.cp;
                o_error_code     <= i_head.cmd.err;
                o_last_of_run    <= 1'b1;
            end
        end
    end

    a_half_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_valid && !o_last_of_run && i_head.valid)
        else $error("second beat lost its command");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !pop |=> r_valid && $stable(o_out_code_point))
        else $error("stalled result beat changed");

endmodule

// ===== rtl/quoted_string_unescaper_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit
// Decodes the characters of a quoted string (text, regex or code form)
// into decoded characters followed by one done or error beat.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         push / full        i_code_point, i_end_of_data,
//                                         i_decode_fault
// result    out        empty / pop        o_result_kind, o_out_code_point,
//                                         o_error_code, o_last_of_run
// config    in         i_cfg_we           i_cfg_data (string mode)
//
// One character is taken per cycle while full is low; the classifier
// updates the escape state on the edge that takes it, and its result beat
// goes through the command queue and then the output register.
// The output register drains one beat per cycle while pop is held, so a
// regex escape that yields backslash plus character takes two output beats.
// Synchronous active-low reset clears the escape state, mode and queue;
// there is no clearing pass. full rises when the queue holds QUEUE_DEPTH
// commands, either behind a stalled result or while a two-beat command
// holds the head; it can hold off input after a regex escape.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_unit
    import qsu_pkg::*;
#(
    parameter int MAX_BRACED_DIGITS = DEF_MAX_BRACED_DIGITS,
    parameter int FIXED_HEX_DIGITS  = DEF_FIXED_HEX_DIGITS,
    parameter int QUEUE_DEPTH       = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [CP_W-1:0]   i_code_point,
    input  logic              i_end_of_data,
    input  logic              i_decode_fault,
    output logic              empty,
    input  logic              pop,
    output logic [KIND_W-1:0] o_result_kind,
    output logic [CP_W-1:0]   o_out_code_point,
    output logic [ERR_W-1:0]  o_error_code,
    output logic              o_last_of_run
);

    logic  accept;
    logic  cmd_valid;
    t_cmd  cmd;
    t_head head;
    logic  deq;

    assign accept = push && !full;

    qsu_front #(
        .MAX_BRACED_DIGITS (MAX_BRACED_DIGITS),
        .FIXED_HEX_DIGITS  (FIXED_HEX_DIGITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_code_point   (i_code_point),
        .i_end_of_data  (i_end_of_data),
        .i_decode_fault (i_decode_fault),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd)
    );

    qsu_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_cmd   (cmd),
        .i_rd    (deq),
        .o_full  (full),
        .o_head  (head)
    );

    qsu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_deq            (deq),
        .pop              (pop),
        .empty            (empty),
        .o_result_kind    (o_result_kind),
        .o_out_code_point (o_out_code_point),
        .o_error_code     (o_error_code),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quoted_string_unescaper_unit. One long string runs
// through text, regex and code modes, with the mode changed between bursts
// while the unit is idle, and ends on a randomly chosen terminator or error.
// Every result beat is predicted and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import qsu_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_PHASE   = 3;

    localparam logic [MODE_W-1:0] MODE_CODE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_ALT = 2'd3;

    localparam logic [CP_W-1:0] CH_LO_T    = 21'h74;
    localparam logic [CP_W-1:0] CH_UP_T    = 21'h54;
    localparam logic [CP_W-1:0] CH_LO_N    = 21'h6E;
    localparam logic [CP_W-1:0] CH_UP_N    = 21'h4E;
    localparam logic [CP_W-1:0] CH_LO_R    = 21'h72;
    localparam logic [CP_W-1:0] CH_UP_R    = 21'h52;
    localparam logic [CP_W-1:0] CH_LO_U    = 21'h75;
    localparam logic [CP_W-1:0] CH_UP_U    = 21'h55;
    localparam logic [CP_W-1:0] CH_DIGIT_0 = 21'h30;
    localparam logic [CP_W-1:0] CH_UP_A    = 21'h41;
    localparam logic [CP_W-1:0] CH_LO_A    = 21'h61;
    localparam logic [CP_W-1:0] CH_BAD_ESC = 21'h71;

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_ESCAPE,
        SCAN_AFTER_U,
        SCAN_FIXED,
        SCAN_BRACED,
        SCAN_CLOSED
    } scan_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eod;
        logic            fault;
    } char_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CP_W-1:0]   cp;
        logic [ERR_W-1:0]  err;
        logic              last;
    } beat_t;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [MODE_W-1:0] i_cfg_data     = '0;
    logic              push           = 1'b0;
    logic              full;
    logic [CP_W-1:0]   i_code_point   = '0;
    logic              i_end_of_data  = 1'b0;
    logic              i_decode_fault = 1'b0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [KIND_W-1:0] o_result_kind;
    logic [CP_W-1:0]   o_out_code_point;
    logic [ERR_W-1:0]  o_error_code;
    logic              o_last_of_run;

    quoted_string_unescaper_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_code_point     (i_code_point),
        .i_end_of_data    (i_end_of_data),
        .i_decode_fault   (i_decode_fault),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (o_result_kind),
        .o_out_code_point (o_out_code_point),
        .o_error_code     (o_error_code),
        .o_last_of_run    (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Decoder state as the unit should hold it
    logic [MODE_W-1:0] dec_mode = MODE_TEXT;
    scan_t             dec_scan = SCAN_NORMAL;
    logic [HEX_W-1:0]  dec_hex  = '0;
    logic [3:0]        dec_ndig = '0;
    beat_t             beats_due[$];

    char_t chars_to_send[$];
    int    n_queued    = 0;
    int    errors      = 0;
    int    phase_no    = 0;
    bit    idle_on     = 1'b1;
    bit    item_taken  = 1'b0;
    bit    hold_used   = 1'b0;
    int    tx_gap      = 0;
    int    rx_gap      = 0;
    int    rx_hold     = 0;

    logic [CP_W-1:0]   text_escapes [9] = '{CP_BACKSLASH, CP_QUOTE, CP_DOLLAR,
        CH_LO_T, CH_UP_T, CH_LO_N, CH_UP_N, CH_LO_R, CH_UP_R};
    logic [MODE_W-1:0] mode_plan [5] = '{MODE_TEXT, MODE_CODE_ALT, MODE_REGEX,
        MODE_TEXT, MODE_CODE};

    function automatic logic [CP_W-1:0] terminator(input logic [MODE_W-1:0] m);
        if (m == MODE_TEXT) return CP_QUOTE;
        if (m == MODE_REGEX) return CP_SLASH;
        return CP_BACKTICK;
    endfunction

    function automatic int hex_digit_value(input logic [CP_W-1:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_0 + 9) return int'(c - CH_DIGIT_0);
        if (c >= CH_UP_A && c <= CH_UP_A + 5) return int'(c - CH_UP_A) + 10;
        if (c >= CH_LO_A && c <= CH_LO_A + 5) return int'(c - CH_LO_A) + 10;
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void post_beat(input logic [KIND_W-1:0] kind,
                                      input logic [CP_W-1:0] cp,
                                      input logic [ERR_W-1:0] err,
                                      input logic last);
        beat_t b;
        b.kind = kind;
        b.cp   = cp;
        b.err  = err;
        b.last = last;
        beats_due.push_back(b);
    endfunction

    function automatic void post_error(input logic [ERR_W-1:0] err);
        dec_scan = SCAN_CLOSED;
        post_beat(K_ERROR, '0, err, 1'b1);
    endfunction

    function automatic void post_scalar();
        dec_scan = SCAN_NORMAL;
        if (dec_hex == 0 || dec_hex > 32'h10FFFF || (dec_hex >= 32'hD800 && dec_hex <= 32'hDFFF))
            post_error(E_SCALAR);
        else
            post_beat(K_CHAR, dec_hex[CP_W-1:0], E_NONE, 1'b1);
    endfunction

    function automatic void decode_char(input char_t ch);
        int         d;
        logic [3:0] nib;
        d   = hex_digit_value(ch.cp);
        nib = d[3:0];
        if (dec_scan == SCAN_CLOSED) return;
        if (ch.eod) begin
            post_error(E_EOD);
            return;
        end
        if (ch.fault) begin
            post_error(E_FAULT);
            return;
        end
        if (ch.cp == CP_LF || ch.cp == CP_CR) begin
            post_error(E_LINE);
            return;
        end
        case (dec_scan)
            SCAN_NORMAL: begin
                if (ch.cp == terminator(dec_mode)) begin
                    dec_scan = SCAN_CLOSED;
                    post_beat(K_DONE, '0, E_NONE, 1'b1);
                end else if (ch.cp == CP_BACKSLASH && dec_mode <= MODE_REGEX) begin
                    dec_scan = SCAN_ESCAPE;
                end else begin
                    post_beat(K_CHAR, ch.cp, E_NONE, 1'b1);
                end
            end
            SCAN_ESCAPE: begin
                dec_scan = SCAN_NORMAL;
                if (dec_mode == MODE_REGEX) begin
                    if (ch.cp == CP_SLASH) begin
                        post_beat(K_CHAR, CP_SLASH, E_NONE, 1'b1);
                    end else begin
                        post_beat(K_CHAR, CP_BACKSLASH, E_NONE, 1'b0);
                        post_beat(K_CHAR, ch.cp, E_NONE, 1'b1);
                    end
                end else begin
                    case (ch.cp)
                        CP_BACKSLASH, CP_QUOTE, CP_DOLLAR: post_beat(K_CHAR, ch.cp, E_NONE, 1'b1);
                        CH_LO_T, CH_UP_T: post_beat(K_CHAR, CP_TAB, E_NONE, 1'b1);
                        CH_LO_N, CH_UP_N: post_beat(K_CHAR, CP_LF, E_NONE, 1'b1);
                        CH_LO_R, CH_UP_R: post_beat(K_CHAR, CP_CR, E_NONE, 1'b1);
                        CH_LO_U, CH_UP_U: begin
                            dec_scan = SCAN_AFTER_U;
                            dec_hex  = '0;
                            dec_ndig = '0;
                        end
                        default: post_error(E_ESCAPE);
                    endcase
                end
            end
            SCAN_AFTER_U: begin
                if (ch.cp == CP_LBRACE) begin
                    dec_scan = SCAN_BRACED;
                    dec_hex  = '0;
                    dec_ndig = '0;
                end else if (d < 0) begin
                    post_error(E_HEX);
                end else begin
                    dec_hex  = {28'd0, nib};
                    dec_ndig = 4'd1;
                    if (dec_ndig >= DEF_FIXED_HEX_DIGITS) post_scalar();
                    else dec_scan = SCAN_FIXED;
                end
            end
            SCAN_FIXED: begin
                if (d < 0) begin
                    post_error(E_HEX);
                end else begin
                    dec_hex  = {dec_hex[HEX_W-5:0], nib};
                    dec_ndig = dec_ndig + 4'd1;
                    if (dec_ndig >= DEF_FIXED_HEX_DIGITS) post_scalar();
                end
            end
            SCAN_BRACED: begin
                if (d >= 0) begin
                    if (dec_ndig >= DEF_MAX_BRACED_DIGITS) begin
                        post_error(E_LONG);
                    end else begin
                        dec_hex  = {dec_hex[HEX_W-5:0], nib};
                        dec_ndig = dec_ndig + 4'd1;
                    end
                end else if (ch.cp == CP_RBRACE && dec_ndig != 0) begin
                    post_scalar();
                end else begin
                    post_error(E_HEX);
                end
            end
            default: dec_scan = SCAN_CLOSED;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void queue_raw(input logic [CP_W-1:0] c, input logic eod,
                                      input logic fault);
        char_t ch;
        ch.cp    = c;
        ch.eod   = eod;
        ch.fault = fault;
        chars_to_send.push_back(ch);
        n_queued++;
    endfunction

    function automatic void queue_char(input logic [CP_W-1:0] c);
        queue_raw(c, 1'b0, 1'b0);
    endfunction

    function automatic logic [CP_W-1:0] hex_char(input int d);
        if (d < 10) return CH_DIGIT_0 + CP_W'(d);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + CP_W'(d - 10);
    endfunction

    function automatic logic [CP_W-1:0] any_char();
        if ($urandom_range(0, 1)) return CP_W'($urandom_range(0, 127));
        return CP_W'($urandom_range(0, 21'h1FFFFF));
    endfunction

    // Plain character that neither ends the string nor opens an escape
    function automatic logic [CP_W-1:0] plain_char(input logic [MODE_W-1:0] m);
        logic [CP_W-1:0] c;
        forever begin
            case ($urandom_range(0, 3))
                0:       c = CP_W'($urandom_range(32, 126));
                1:       c = CP_W'($urandom_range(0, 255));
                2:       c = CP_W'($urandom_range(0, 21'h10FFFF));
                default: c = CP_W'($urandom_range(0, 21'h1FFFFF));
            endcase
            if (c != CP_LF && c != CP_CR && c != terminator(m)
                && !(c == CP_BACKSLASH && m <= MODE_REGEX))
                return c;
        end
    endfunction

    function automatic logic [CP_W-1:0] non_hex_char();
        logic [CP_W-1:0] c;
        forever begin
            c = any_char();
            if (hex_digit_value(c) < 0 && c != CP_LF && c != CP_CR
                && c != CP_LBRACE && c != CP_RBRACE)
                return c;
        end
    endfunction

    function automatic logic [HEX_W-1:0] random_scalar(input logic [HEX_W-1:0] top);
        logic [HEX_W-1:0] v;
        forever begin
            case ($urandom_range(0, 2))
                0:       v = $urandom_range(1, 127);
                1:       v = $urandom_range(1, 32'hFFFF);
                default: v = $urandom_range(1, top);
            endcase
            if (v <= top && !(v >= 32'hD800 && v <= 32'hDFFF)) return v;
        end
    endfunction

    function automatic void queue_u_prefix(input bit braced);
        queue_char(CP_BACKSLASH);
        queue_char($urandom_range(0, 1) ? CH_LO_U : CH_UP_U);
        if (braced) queue_char(CP_LBRACE);
    endfunction

    function automatic void queue_hex_escape(input logic [HEX_W-1:0] v, input bit braced,
                                             input int ndig);
        queue_u_prefix(braced);
        for (int i = ndig - 1; i >= 0; i--) queue_char(hex_char(int'(v[4*i +: 4])));
        if (braced) queue_char(CP_RBRACE);
    endfunction

    // One well-formed unit of string content; leaves the decoder in normal state
    function automatic void queue_unit(input logic [MODE_W-1:0] m);
        logic [HEX_W-1:0] v;
        int               nmin;
        int               sel;
        sel = $urandom_range(0, 9);
        if (m == MODE_TEXT && sel == 5) begin
            queue_char(CP_BACKSLASH);
            queue_char(text_escapes[$urandom_range(0, 8)]);
        end else if (m == MODE_TEXT && sel >= 6 && sel <= 7) begin
            queue_hex_escape(random_scalar(32'hFFFF), 1'b0, DEF_FIXED_HEX_DIGITS);
        end else if (m == MODE_TEXT && sel >= 8) begin
            v    = random_scalar(32'h10FFFF);
            nmin = 1;
            while ((v >> (4 * nmin)) != 0) nmin++;
            queue_hex_escape(v, 1'b1, $urandom_range(nmin, DEF_MAX_BRACED_DIGITS));
        end else if (m == MODE_REGEX && sel >= 6) begin
            queue_char(CP_BACKSLASH);
            if (sel >= 8) begin
                queue_char(CP_SLASH);
            end else begin
                v = HEX_W'(any_char());
                queue_char((v == CP_LF || v == CP_CR) ? CP_BACKSLASH : v[CP_W-1:0]);
            end
        end else begin
            queue_char(plain_char(m));
        end
    endfunction

    // Close the string with the done beat or with one of the error cases
    function automatic void queue_ending(input logic [MODE_W-1:0] m);
        case ((m == MODE_TEXT) ? $urandom_range(0, 11) : $urandom_range(0, 4))
            0: queue_char(terminator(m));
            // end of data wins over a fault on the same item
            1: queue_raw(any_char(), 1'b1, 1'($urandom_range(0, 1)));
            // a fault wins over a line break
            2: queue_raw($urandom_range(0, 1) ? CP_LF : any_char(), 1'b0, 1'b1);
            3: queue_char($urandom_range(0, 1) ? CP_LF : CP_CR);
            4: begin
                if (m <= MODE_REGEX) queue_char(CP_BACKSLASH);
                queue_char($urandom_range(0, 1) ? CP_LF : CP_CR);
            end
            5: begin
                queue_char(CP_BACKSLASH);
                queue_char(CH_BAD_ESC);
            end
            6: begin
                queue_u_prefix(1'b0);
                queue_char(non_hex_char());
            end
            7: begin
                queue_u_prefix(1'b0);
                repeat ($urandom_range(1, DEF_FIXED_HEX_DIGITS - 1))
                    queue_char(hex_char($urandom_range(0, 15)));
                queue_char($urandom_range(0, 1) ? non_hex_char() : CP_RBRACE);
            end
            8: begin
                queue_u_prefix(1'b1);
                queue_char(CP_RBRACE);
            end
            9: begin
                queue_u_prefix(1'b1);
                repeat ($urandom_range(0, DEF_MAX_BRACED_DIGITS))
                    queue_char(hex_char($urandom_range(0, 15)));
                queue_char($urandom_range(0, 1) ? non_hex_char() : CP_LBRACE);
            end
            10: begin
                queue_u_prefix(1'b1);
                repeat (DEF_MAX_BRACED_DIGITS + 1) queue_char(hex_char($urandom_range(0, 15)));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: queue_hex_escape('0, 1'b0, DEF_FIXED_HEX_DIGITS);
                    1: queue_hex_escape($urandom_range(32'hD800, 32'hDFFF), 1'b0,
                                        DEF_FIXED_HEX_DIGITS);
                    2: queue_hex_escape('0, 1'b1, $urandom_range(1, DEF_MAX_BRACED_DIGITS));
                    default: queue_hex_escape($urandom_range(32'h110000, 32'hFFFFFFFF), 1'b1,
                                              DEF_MAX_BRACED_DIGITS);
                endcase
            end
        endcase
    endfunction

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every beat, then let trailing no-result characters settle
    task automatic settle();
        while (chars_to_send.size() != 0 || beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: one character per beat from the pending queue
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (item_taken) chars_to_send.delete(0);
        if (!i_rst_n || chars_to_send.size() == 0) begin
            push <= 1'b0;
        end else if (tx_gap > 0) begin
            tx_gap--;
            push <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 15);
            push <= 1'b0;
        end else begin
            push           <= 1'b1;
            i_code_point   <= chars_to_send[0].cp;
            i_end_of_data  <= chars_to_send[0].eod;
            i_decode_fault <= chars_to_send[0].fault;
        end
    end

    // Receiver: random stall bursts plus one long hold to back up the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (!hold_used && phase_no == HOLD_PHASE) begin
            hold_used = 1'b1;
            rx_hold   = LONG_HOLD;
            pop <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 15);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and predictor update
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        beat_t want;
        char_t seen;
        item_taken = i_rst_n && push && !full;
        if (i_rst_n && pop && !empty) begin
            if (beats_due.size() == 0) begin
                $error("result beat with none expected: kind %0d cp %0h err %0d",
                       o_result_kind, o_out_code_point, o_error_code);
                errors++;
            end else begin
                want = beats_due.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, o_result_kind);
                    errors++;
                end
                if (o_out_code_point !== want.cp) begin
                    $error("out_code_point: expected %0h, got %0h", want.cp, o_out_code_point);
                    errors++;
                end
                if (o_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
        if (item_taken) begin
            seen.cp    = i_code_point;
            seen.eod   = i_end_of_data;
            seen.fault = i_decode_fault;
            decode_char(seen);
        end
        if (i_rst_n && i_cfg_we) dec_mode = i_cfg_data;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [MODE_W-1:0] m;
        int                n;
        int                target;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes and the fixed escapes
        write_mode(MODE_TEXT);
        queue_char(21'h0);
        queue_char(21'h1FFFFF);
        queue_char(CP_BACKSLASH);
        queue_char(CP_QUOTE);
        queue_char(CP_BACKSLASH);
        queue_char(CP_DOLLAR);
        queue_char(CP_BACKSLASH);
        queue_char(CH_LO_T);
        queue_char(CP_BACKSLASH);
        queue_char(CH_UP_N);
        queue_hex_escape(32'h10FFFF, 1'b1, DEF_MAX_BRACED_DIGITS);
        settle();
        write_mode(MODE_REGEX);
        queue_char(CP_BACKSLASH);
        queue_char(CP_SLASH);
        queue_char(CP_BACKSLASH);
        queue_char(CP_BACKSLASH);
        settle();
        write_mode(MODE_CODE);
        queue_char(CP_BACKSLASH);
        settle();

        target = n_queued + RANDOM_ITEMS;
        while (n_queued < target) begin
            phase_no++;
            if (phase_no <= 5) m = mode_plan[phase_no - 1];
            else if ($urandom_range(0, 1)) m = MODE_TEXT;
            else m = MODE_W'($urandom_range(0, 3));
            // no idling in the last part of the run
            idle_on = (target - n_queued > RANDOM_ITEMS / 5) && ($urandom_range(0, 3) != 0);
            write_mode(m);
            n = n_queued + $urandom_range(60, 220);
            while (n_queued < n && n_queued < target) queue_unit(m);
            settle();
        end

        idle_on = 1'b0;
        m = $urandom_range(0, 1) ? MODE_TEXT : MODE_W'($urandom_range(0, 3));
        write_mode(m);
        repeat ($urandom_range(0, 8)) queue_unit(m);
        queue_ending(m);
        // trailing characters after the string closed; all dropped
        for (int i = 0; i < 24; i++)
            queue_raw(CP_W'($urandom_range(0, 21'h1FFFFF)), i == 0 || $urandom_range(0, 1),
                      i == 0 || $urandom_range(0, 1));

        while (chars_to_send.size() != 0 || beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
